// ===== src/ccot_pkg.sv =====
// ----------------------------------------------------------------------------
// ccot_pkg
// Shared types, codes and sizes of the coarse counter offset tracker.
// ----------------------------------------------------------------------------
package ccot_pkg;

  localparam int CHANNELS     = 16;
  localparam int COUNTER_BITS = 11;
  localparam int CH_W         = 4;
  localparam int SKIP_W       = 4;

  localparam logic [SKIP_W-1:0] SKIP_RESET = SKIP_W'(3);

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [CH_W-1:0]         chan_t;
  typedef logic [SKIP_W-1:0]       skip_t;
  typedef logic [2:0]              status_t;
  typedef logic [1:0]              cmd_t;

  localparam cmd_t CMD_EVENT   = 2'd0;
  localparam cmd_t CMD_TRACK   = 2'd1;
  localparam cmd_t CMD_CORRECT = 2'd2;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_STARTED = 3'd1;
  localparam status_t ST_HELD    = 3'd2;
  localparam status_t ST_FAILED  = 3'd3;
  localparam status_t ST_IGNORED = 3'd4;

  localparam logic REG_SKIP = 1'b0;

  typedef enum logic [1:0] {
    WOP_NONE,
    WOP_TRACK,
    WOP_CORRECT,
    WOP_CLEAR
  } win_op_t;

  typedef struct packed {
    win_op_t op;
    chan_t   channel;
    cnt_t    diff;
    cnt_t    raw;
  } win_req_t;

  typedef struct packed {
    status_t status;
    cnt_t    lo;
    cnt_t    hi;
    logic    valid;
    cnt_t    corr;
  } win_rsp_t;

endpackage

// ===== src/ccot_cfg.sv =====
// ----------------------------------------------------------------------------
// ccot_cfg
// APB-style configuration register holding the post-failure skip count.
// ----------------------------------------------------------------------------
module ccot_cfg
  import ccot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output skip_t       skip_after_failure
);

  skip_t skip_r;
  logic  wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_SKIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
    end else if (wr_en) begin
      skip_r <= cfg_pwdata[SKIP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SKIP) ? {(32-SKIP_W)'(0), skip_r} : 32'd0;
  assign skip_after_failure = skip_r;

endmodule

// ===== src/ccot_window.sv =====
// ----------------------------------------------------------------------------
// ccot_window
// Per-channel offset windows: track, correct and clear-all logic.
// ----------------------------------------------------------------------------
module ccot_window
  import ccot_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  win_req_t req,
  output win_rsp_t rsp
);

  cnt_t                win_low_r  [CHANNELS];
  cnt_t                win_high_r [CHANNELS];
  logic [CHANNELS-1:0] win_set_r;

  cnt_t    lo, hi, d;
  logic    set;
  cnt_t    lo_nxt, hi_nxt;
  logic    set_nxt;
  status_t st;
  cnt_t    corr;

  always_comb begin
    lo      = win_low_r[req.channel];
    hi      = win_high_r[req.channel];
    set     = win_set_r[req.channel];
    d       = req.diff;
    lo_nxt  = lo;
    hi_nxt  = hi;
    set_nxt = set;
    st      = ST_OK;
    corr    = '0;
    case (req.op)
      WOP_TRACK: begin
        if (!set) begin
          lo_nxt  = d;
          hi_nxt  = d;
          set_nxt = 1'b1;
          st      = ST_STARTED;
        end else if (d == hi) begin
          st = ST_HELD;
        end else if (cnt_t'(d + cnt_t'(1)) == hi) begin
          if (lo == hi) lo_nxt = cnt_t'(hi - cnt_t'(1));
          st = ST_HELD;
        end else if (cnt_t'(d + cnt_t'(2)) == hi) begin
          if (cnt_t'(lo + cnt_t'(2)) != hi) lo_nxt = cnt_t'(hi - cnt_t'(2));
          st = ST_HELD;
        end else if (d == cnt_t'(lo + cnt_t'(1))) begin
          if (lo == hi) hi_nxt = cnt_t'(lo + cnt_t'(1));
          st = ST_HELD;
        end else if (d == cnt_t'(lo + cnt_t'(2))) begin
          if (cnt_t'(lo + cnt_t'(2)) != hi) hi_nxt = cnt_t'(lo + cnt_t'(2));
          st = ST_HELD;
        end else begin
          lo_nxt  = '0;
          hi_nxt  = '0;
          set_nxt = 1'b0;
          st      = ST_FAILED;
        end
      end
      WOP_CORRECT: begin
        corr = set ? cnt_t'(req.raw + lo) : req.raw;
      end
      default: begin
      end
    endcase
  end

  assign rsp.status = st;
  assign rsp.valid  = set_nxt;
  assign rsp.lo     = set_nxt ? lo_nxt : '0;
  assign rsp.hi     = set_nxt ? hi_nxt : '0;
  assign rsp.corr   = corr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_set_r <= '0;
    end else if (req.op == WOP_CLEAR) begin
      win_set_r <= '0;
    end else if (req.op == WOP_TRACK) begin
      win_set_r[req.channel] <= set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.op == WOP_TRACK) begin
      win_low_r[req.channel]  <= lo_nxt;
      win_high_r[req.channel] <= hi_nxt;
    end
  end

endmodule

// ===== src/coarse_counter_offset_tracker_top.sv =====
// A request is held in the input register, then passes through the channel window into the result register.
// Throughput: one request per cycle while results are taken, set by the single pass through the channel window.
// The input register refills while the result register is being taken.
// Reset (rst_n low, synchronous): all channels unset, skip count and skip flag cleared,
// skip_after_failure back to 3.
// ----------------------------------------------------------------------------
// coarse_counter_offset_tracker_top
// Coarse counter offset tracker with event skipping after readout failures.
// ----------------------------------------------------------------------------
module coarse_counter_offset_tracker_top
  import ccot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // channel, trig_coarse, ref_coarse, raw_coarse, zero pad
  input  logic [2:0]  in_tuser,  // cmd[1:0], daq_failure
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // offset_left, offset_right, offset_valid,
                                 // corrected_coarse, zero pad
  output logic [2:0]  out_tuser, // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [CH_W:0] CHANNELS_L = (CH_W+1)'(CHANNELS);

  skip_t    skip_cfg;
  logic     in_valid_r;
  cmd_t     cmd_r;
  logic     fail_r;
  chan_t    chan_r;
  cnt_t     trig_r, ref_r, raw_r;
  skip_t    skip_count_r, skip_count_nxt;
  logic     skipped_r, skipped_nxt;
  logic     out_valid_r;
  status_t  out_status_r, status_nxt;
  logic [39:0] out_data_r, data_nxt;
  logic     fire;
  skip_t    sc;
  win_req_t req;
  win_rsp_t rsp;

  ccot_cfg u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .skip_after_failure (skip_cfg)
  );

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser[1:0];
      fail_r <= in_tuser[2];
      chan_r <= in_tdata[3:0];
      trig_r <= in_tdata[14:4];
      ref_r  <= in_tdata[25:15];
      raw_r  <= in_tdata[36:26];
    end
  end

  always_comb begin
    req.op      = WOP_NONE;
    req.channel = chan_r;
    req.diff    = cnt_t'(ref_r - trig_r);
    req.raw     = raw_r;
    skip_count_nxt = skip_count_r;
    skipped_nxt    = skipped_r;
    status_nxt     = ST_IGNORED;
    data_nxt       = '0;
    sc             = fail_r ? skip_cfg : skip_count_r;
    if (cmd_r == CMD_EVENT) begin
      if (fire && fail_r) req.op = WOP_CLEAR;
      if (sc != '0) begin
        skip_count_nxt = skip_t'(sc - skip_t'(1));
        skipped_nxt    = 1'b1;
        status_nxt     = ST_IGNORED;
      end else begin
        skip_count_nxt = sc;
        skipped_nxt    = 1'b0;
        status_nxt     = ST_OK;
      end
    end else if ((cmd_r == CMD_TRACK || cmd_r == CMD_CORRECT) && !skipped_r &&
                 ({1'b0, chan_r} < CHANNELS_L)) begin
      if (fire) req.op = (cmd_r == CMD_TRACK) ? WOP_TRACK : WOP_CORRECT;
      status_nxt = rsp.status;
      data_nxt   = {6'd0, rsp.corr, rsp.valid, rsp.hi, rsp.lo};
    end
  end

  ccot_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= '0;
      skipped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        skip_count_r <= skip_count_nxt;
        skipped_r    <= skipped_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_data_r   <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_started_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_STARTED) |-> out_tdata[22])
    else $error("started window not marked valid");

  a_failed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FAILED) |-> (out_tdata[22:0] == 23'd0))
    else $error("failed window not cleared");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_IGNORED) |-> (out_tdata == 40'd0))
    else $error("ignored request carries data");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_skip_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r == CMD_EVENT && status_nxt == ST_IGNORED) |=> skipped_r)
    else $error("skipped event did not set skip flag");
`endif

endmodule
